// ----- hw/rtl/bnt_pkg.sv -----
// ----------------------------------------------------------------------------
// bnt_pkg
// Shared widths, payload structs and defaults for the batch-norm forward block.
// ----------------------------------------------------------------------------
package bnt_pkg;

   localparam int LANES         = 8;
   localparam int BATCH_DEFAULT = 8;

   localparam int X_W      = 16;                 // Q8.8 sample / scale / shift
   localparam int EPS_W    = 16;
   localparam int SUM_W    = X_W + 3;            // sum of up to eight samples
   localparam int DEV_W    = SUM_W + 1;          // BATCH*x - sum
   localparam int SQ_W     = 2 * DEV_W;          // squared deviation
   localparam int SQSUM_W  = SQ_W + 3;           // sum of eight squares
   localparam int S_W      = 31;                 // var + eps, Q16.16
   localparam int ROOT_W   = 24;                 // sqrt(s << 16)
   localparam int RAD_W    = 2 * ROOT_W;         // radicand
   localparam int DEN_W    = ROOT_W + 3;         // BATCH * root
   localparam int PROD_W   = DEV_W + X_W;        // deviation * scale
   localparam int MAG_W    = PROD_W + 8;         // |d * scale| * 256
   localparam int QUO_W    = 17;                 // quotient bits before clip
   localparam int T_W      = QUO_W + 2;          // signed term plus shift

   typedef struct packed {
      logic signed [X_W-1:0] sample_0;
      logic signed [X_W-1:0] sample_1;
      logic signed [X_W-1:0] sample_2;
      logic signed [X_W-1:0] sample_3;
      logic signed [X_W-1:0] sample_4;
      logic signed [X_W-1:0] sample_5;
      logic signed [X_W-1:0] sample_6;
      logic signed [X_W-1:0] sample_7;
      logic signed [X_W-1:0] scale;
      logic signed [X_W-1:0] shift;
   } bnt_req_type;

   typedef struct packed {
      logic signed [X_W-1:0] result_0;
      logic signed [X_W-1:0] result_1;
      logic signed [X_W-1:0] result_2;
      logic signed [X_W-1:0] result_3;
      logic signed [X_W-1:0] result_4;
      logic signed [X_W-1:0] result_5;
      logic signed [X_W-1:0] result_6;
      logic signed [X_W-1:0] result_7;
      logic                  saturated;
   } bnt_rsp_type;

endpackage

// ----- hw/rtl/batch_norm_train_forward.sv -----
// ----------------------------------------------------------------------------
// batch_norm_train_forward
// Training-mode batch normalization of one feature position per request:
// batch mean and population variance, normalize, scale, shift, saturate.
// Throughput: one request per cycle; the whole pipeline advances as one,
// gated by the output register (it stalls only while rsp holds and is stalled).
// Reset clears all valid bits and rsp_valid; epsilon resets to 1.
// ----------------------------------------------------------------------------
module batch_norm_train_forward #(
   parameter int BATCH = bnt_pkg::BATCH_DEFAULT    // 2..8 samples used
) (
   input  logic                              clock,
   input  logic                              reset,
   // requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bnt_pkg::bnt_req_type              req_data,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bnt_pkg::bnt_rsp_type              rsp_data,
   // epsilon register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bnt_pkg::EPS_W-1:0]         csr_data
);
   import bnt_pkg::*;

   // Pipeline stage map (stage k = k registers after accept):
   //   1  samples, batch sum          2  deviations (lanes)
   //   3  squares, d*scale (lanes)    4  sum of squares (merge)
   //   5  partial products of sum * (1/BATCH^3)
   //   6  s = var + eps               7..30 square root, one bit per stage
   //   31 den = BATCH*root            32..49 divide (load + 17 bits)
   //   50 response register
   localparam int SQRT_END   = 6 + ROOT_W;
   localparam int DEN_STAGE  = SQRT_END + 1;
   localparam int MAG_ALIGN  = DEN_STAGE - 4;
   localparam int PIPE_DEPTH = DEN_STAGE + 1 + QUO_W;
   localparam int BatchCube  = BATCH * BATCH * BATCH;

   // floor(a / BATCH^3) = (a * RECIP) >> RECIP_SH for every a below 2^SQSUM_W
   localparam int          RECIP_SH = SQSUM_W + $clog2(BatchCube);
   localparam logic [63:0] RECIP    =
      ((64'd1 << RECIP_SH) + 64'(BatchCube) - 64'd1) / 64'(BatchCube);
   localparam int          HALF_W   = 22;
   localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
   localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];

   logic                  adv;
   logic [EPS_W-1:0]      eps_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;
   bnt_rsp_type           rsp_ff;
   bnt_rsp_type           rsp_in;

   logic signed [X_W-1:0]   x_in  [LANES];
   logic signed [X_W-1:0]   x_ff  [LANES];
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [X_W-1:0]   g1_ff;
   logic signed [X_W-1:0]   g2_ff;
   logic signed [X_W-1:0]   b_dly_ff [DEN_STAGE];
   logic [SQ_W-1:0]         sq_lane  [LANES];
   logic [SQSUM_W-1:0]      sqsum_in;
   logic [SQSUM_W-1:0]      sqsum_ff;
   logic [2*HALF_W-1:0]     pp_ll_ff;
   logic [2*HALF_W-1:0]     pp_lh_ff;
   logic [2*HALF_W-1:0]     pp_hl_ff;
   logic [2*HALF_W-1:0]     pp_hh_ff;
   logic [4*HALF_W-1:0]     quo_full;
   logic [S_W-1:0]          var_q;
   logic [S_W-1:0]          s_ff;
   logic [ROOT_W-1:0]       root;
   logic [DEN_W-1:0]        den_ff;
   logic signed [X_W-1:0]   res_lane [LANES];
   logic                    sat_lane [LANES];

   // Whole pipe moves whenever the response register is free or being taken.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_W'(1);
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // ---- stage 1: capture samples, batch sum over the used lanes ----
   always_comb begin
      x_in[0] = req_data.sample_0;
      x_in[1] = req_data.sample_1;
      x_in[2] = req_data.sample_2;
      x_in[3] = req_data.sample_3;
      x_in[4] = req_data.sample_4;
      x_in[5] = req_data.sample_5;
      x_in[6] = req_data.sample_6;
      x_in[7] = req_data.sample_7;
      sum_in  = '0;
      for (int i = 0; i < BATCH; i++) begin
         sum_in = sum_in + SUM_W'(x_in[i]);
      end
   end

   // ---- merge: sum of squared deviations ----
   always_comb begin
      sqsum_in = '0;
      for (int i = 0; i < BATCH; i++) begin
         sqsum_in = sqsum_in + SQSUM_W'(sq_lane[i]);
      end
   end

   // ---- variance: recombine the partial products, keep the quotient ----
   always_comb begin
      quo_full = {pp_hh_ff, {(2*HALF_W){1'b0}}}
               + ((4*HALF_W)'(pp_lh_ff) << HALF_W)
               + ((4*HALF_W)'(pp_hl_ff) << HALF_W)
               + (4*HALF_W)'(pp_ll_ff);
      var_q    = quo_full[RECIP_SH +: S_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            x_ff[i] <= x_in[i];
         end
         sum_ff      <= sum_in;
         g1_ff       <= req_data.scale;
         g2_ff       <= g1_ff;
         b_dly_ff[0] <= req_data.shift;
         for (int k = 1; k < DEN_STAGE; k++) begin
            b_dly_ff[k] <= b_dly_ff[k-1];
         end
         sqsum_ff    <= sqsum_in;
         // split multiply by the reciprocal of BATCH^3
         pp_ll_ff    <= sqsum_ff[HALF_W-1:0] * RECIP_LO;
         pp_lh_ff    <= sqsum_ff[HALF_W-1:0] * RECIP_HI;
         pp_hl_ff    <= sqsum_ff[SQSUM_W-1:HALF_W] * RECIP_LO;
         pp_hh_ff    <= sqsum_ff[SQSUM_W-1:HALF_W] * RECIP_HI;
         // population variance in Q16.16, then add epsilon
         s_ff        <= var_q + S_W'(eps_ff);
         den_ff      <= DEN_W'(root * BATCH);
      end
   end

   // ---- square root of s in Q16.16 -> root with 16 fraction bits ----
   bnt_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand ({1'b0, s_ff, 16'b0}),
      .root     (root)
   );

   // ---- lanes: deviation, square, numerator, divide, saturate ----
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i < BATCH) begin : g_used
         logic [MAG_W-1:0] mag;
         logic             neg;

         bnt_lane #(
            .BATCH (BATCH),
            .ALIGN (MAG_ALIGN)
         ) u_lane (
            .clock (clock),
            .en    (adv),
            .x     (x_ff[i]),
            .sum   (sum_ff),
            .scale (g2_ff),
            .sq    (sq_lane[i]),
            .mag   (mag),
            .neg   (neg)
         );

         bnt_div u_div (
            .clock  (clock),
            .en     (adv),
            .mag    (mag),
            .neg    (neg),
            .den    (den_ff),
            .shift  (b_dly_ff[DEN_STAGE-1]),
            .result (res_lane[i]),
            .sat    (sat_lane[i])
         );
      end else begin : g_unused
         // lanes past the batch size read as zero and never saturate
         assign sq_lane[i]  = '0;
         assign res_lane[i] = '0;
         assign sat_lane[i] = 1'b0;
      end
   end

   // ---- response register ----
   always_comb begin
      rsp_in.result_0  = res_lane[0];
      rsp_in.result_1  = res_lane[1];
      rsp_in.result_2  = res_lane[2];
      rsp_in.result_3  = res_lane[3];
      rsp_in.result_4  = res_lane[4];
      rsp_in.result_5  = res_lane[5];
      rsp_in.result_6  = res_lane[6];
      rsp_in.result_7  = res_lane[7];
      rsp_in.saturated = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         rsp_in.saturated = rsp_in.saturated | sat_lane[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- hw/rtl/bnt_lane.sv -----
// ----------------------------------------------------------------------------
// bnt_lane
// Per-sample front end: deviation, its square, and the scaled numerator
// magnitude, delayed to meet the denominator.
// ----------------------------------------------------------------------------
module bnt_lane #(
   parameter int BATCH = bnt_pkg::BATCH_DEFAULT,
   parameter int ALIGN = 26
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [bnt_pkg::X_W-1:0]    x,       // stage 1
   input  logic signed [bnt_pkg::SUM_W-1:0]  sum,     // stage 1
   input  logic signed [bnt_pkg::X_W-1:0]    scale,   // stage 2
   output logic        [bnt_pkg::SQ_W-1:0]   sq,      // stage 3
   output logic        [bnt_pkg::MAG_W-1:0]  mag,     // stage 4 + ALIGN
   output logic                              neg
);
   import bnt_pkg::*;

   localparam logic signed [DEV_W-1:0] NB = DEV_W'(BATCH);

   logic signed [DEV_W-1:0]    xe;
   logic signed [DEV_W-1:0]    se;
   logic signed [DEV_W-1:0]    dev_in;
   logic signed [DEV_W-1:0]    dev_ff;
   logic signed [SQ_W-1:0]     sq_in;
   logic        [SQ_W-1:0]     sq_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic        [PROD_W-1:0]   abs_prod;
   logic        [MAG_W-1:0]    mag_dly_ff [ALIGN+1];
   logic                       neg_dly_ff [ALIGN+1];

   always_comb begin
      xe      = DEV_W'(x);
      se      = DEV_W'(sum);
      dev_in  = xe * NB - se;
      sq_in   = dev_ff * dev_ff;
      prod_in = dev_ff * scale;
      abs_prod = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dev_ff        <= dev_in;
         sq_ff         <= SQ_W'(sq_in);
         prod_ff       <= prod_in;
         mag_dly_ff[0] <= {abs_prod, 8'b0};
         neg_dly_ff[0] <= prod_ff[PROD_W-1];
         for (int k = 1; k <= ALIGN; k++) begin
            mag_dly_ff[k] <= mag_dly_ff[k-1];
            neg_dly_ff[k] <= neg_dly_ff[k-1];
         end
      end
   end

   assign sq  = sq_ff;
   assign mag = mag_dly_ff[ALIGN];
   assign neg = neg_dly_ff[ALIGN];

endmodule

// ----- hw/rtl/bnt_sqrt.sv -----
// ----------------------------------------------------------------------------
// bnt_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bnt_sqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [bnt_pkg::RAD_W-1:0]      radicand,
   output logic [bnt_pkg::ROOT_W-1:0]     root
);
   import bnt_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1:RAD_W-2]};
         trial  = {root_src, 2'b01};
         fits   = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? rem_sh - trial : rem_sh;
            root_ff[k] <= {root_src[ROOT_W-2:0], fits};
            rad_ff[k]  <= rad_src << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// ----- hw/rtl/bnt_div.sv -----
// ----------------------------------------------------------------------------
// bnt_div
// Pipelined rounding divide, shift add and Q8.8 saturation for one lane.
// ----------------------------------------------------------------------------
module bnt_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic        [bnt_pkg::MAG_W-1:0]   mag,
   input  logic                               neg,
   input  logic        [bnt_pkg::DEN_W-1:0]   den,
   input  logic signed [bnt_pkg::X_W-1:0]     shift,
   output logic signed [bnt_pkg::X_W-1:0]     result,
   output logic                               sat
);
   import bnt_pkg::*;

   localparam logic signed [T_W-1:0] Y_MAX = T_W'(32767);
   localparam logic signed [T_W-1:0] Y_MIN = -T_W'(32768);

   // load stage
   logic [MAG_W-1:0]        num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic                    neg_ff;
   logic                    zero_ff;
   logic signed [X_W-1:0]   b_ff;

   // divide steps
   logic [MAG_W-1:0]        rem_ff   [QUO_W];
   logic [QUO_W-1:0]        quo_ff   [QUO_W];
   logic [DEN_W-1:0]        dsr_ff   [QUO_W];
   logic                    sgn_ff   [QUO_W];
   logic                    zr_ff    [QUO_W];
   logic                    ovf_ff   [QUO_W];
   logic signed [X_W-1:0]   sh_ff    [QUO_W];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= mag + MAG_W'(den >> 1);
         den_ff  <= den;
         neg_ff  <= neg;
         zero_ff <= (den == '0);
         b_ff    <= shift;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - 1 - j;
      logic [MAG_W-1:0]      rem_src;
      logic [QUO_W-1:0]      quo_src;
      logic [DEN_W-1:0]      dsr_src;
      logic                  sgn_src;
      logic                  zr_src;
      logic                  ovf_src;
      logic signed [X_W-1:0] sh_src;
      logic [MAG_W-1:0]      dsh;
      logic                  fits;

      if (j == 0) begin : g_first
         assign rem_src = num_ff;
         assign quo_src = '0;
         assign dsr_src = den_ff;
         assign sgn_src = neg_ff;
         assign zr_src  = zero_ff;
         assign ovf_src = num_ff >= (MAG_W'(den_ff) << QUO_W);
         assign sh_src  = b_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign dsr_src = dsr_ff[j-1];
         assign sgn_src = sgn_ff[j-1];
         assign zr_src  = zr_ff[j-1];
         assign ovf_src = ovf_ff[j-1];
         assign sh_src  = sh_ff[j-1];
      end

      always_comb begin
         dsh  = MAG_W'(dsr_src) << BIT;
         fits = rem_src >= dsh;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]      <= fits ? rem_src - dsh : rem_src;
            quo_ff[j]      <= quo_src | (QUO_W'(fits) << BIT);
            dsr_ff[j]      <= dsr_src;
            sgn_ff[j]      <= sgn_src;
            zr_ff[j]       <= zr_src;
            ovf_ff[j]      <= ovf_src;
            sh_ff[j]       <= sh_src;
         end
      end
   end

   logic [QUO_W-1:0]        q_clip;
   logic signed [T_W-1:0]   t_val;
   logic signed [T_W-1:0]   y_val;

   always_comb begin
      // a quotient past the clip level saturates anyway
      q_clip = ovf_ff[QUO_W-1] ? '1 : quo_ff[QUO_W-1];
      if (zr_ff[QUO_W-1]) begin
         t_val = '0;
      end else if (sgn_ff[QUO_W-1]) begin
         t_val = -$signed(T_W'(q_clip));
      end else begin
         t_val = $signed(T_W'(q_clip));
      end
      y_val = t_val + T_W'(sh_ff[QUO_W-1]);
      priority if (y_val > Y_MAX) begin
         result = X_W'(Y_MAX);
         sat    = 1'b1;
      end else if (y_val < Y_MIN) begin
         result = X_W'(Y_MIN);
         sat    = 1'b1;
      end else begin
         result = X_W'(y_val);
         sat    = 1'b0;
      end
   end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for batch_norm_train_forward: directed corner requests,
// then random requests with random idling on both sides. A scoreboard class
// predicts each result from the request and the epsilon register in force.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bnt_pkg::*;

   localparam int NB        = 8;       // BATCH used by the instance
   localparam int DRAIN     = 80;      // margin beyond the pipeline latency
   localparam int DOG_LIMIT = 4000;    // idle cycles before giving up

   // -------------------------------------------------------------------------
   // Scoreboard: holds the predicted results in request order.
   // -------------------------------------------------------------------------
   class bn_scoreboard;
      bnt_rsp_type norm_q[$];
      logic [15:0] eps_val = 16'd1;
      int          errors  = 0;

      static function logic [63:0] sqrt_floor(logic [63:0] v);
         logic [63:0] root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v    = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function void note_request(bnt_req_type rq);
         longint      x[NB];
         longint      dev[NB];
         longint      sum, num, y, t;
         logic [63:0] sq, var_q, s, root, den, mag, q;
         bnt_rsp_type rs;
         logic [15:0] res[8];
         x[0] = rq.sample_0; x[1] = rq.sample_1; x[2] = rq.sample_2;
         x[3] = rq.sample_3; x[4] = rq.sample_4; x[5] = rq.sample_5;
         x[6] = rq.sample_6; x[7] = rq.sample_7;
         sum = 0;
         sq  = 0;
         for (int i = 0; i < NB; i++) sum += x[i];
         for (int i = 0; i < NB; i++) begin
            dev[i] = NB * x[i] - sum;
            sq += dev[i] * dev[i];
         end
         var_q = sq / (NB * NB * NB);
         s     = var_q + eps_val;
         root  = sqrt_floor(s << 16);
         den   = NB * root;
         rs    = '0;
         for (int i = 0; i < 8; i++) begin
            res[i] = 16'd0;
            if (i < NB) begin
               t = 0;
               if (den != 0) begin
                  num = dev[i] * longint'(rq.scale) * 256;
                  mag = (num < 0) ? -num : num;
                  q   = (mag + den / 2) / den;
                  t   = (num < 0) ? -longint'(q) : longint'(q);
               end
               y = t + rq.shift;
               if (y > 32767) begin
                  y = 32767;
                  rs.saturated = 1'b1;
               end else if (y < -32768) begin
                  y = -32768;
                  rs.saturated = 1'b1;
               end
               res[i] = y[15:0];
            end
         end
         rs.result_0 = res[0]; rs.result_1 = res[1]; rs.result_2 = res[2];
         rs.result_3 = res[3]; rs.result_4 = res[4]; rs.result_5 = res[5];
         rs.result_6 = res[6]; rs.result_7 = res[7];
         norm_q.insert(norm_q.size(), rs);
      endfunction

      function void check_result(bnt_rsp_type got);
         bnt_rsp_type exp_r;
         if (norm_q.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         exp_r = norm_q.pop_front();
         if (got.result_0 !== exp_r.result_0) begin
            $error("result_0 exp %0d got %0d", exp_r.result_0, got.result_0); errors++;
         end
         if (got.result_1 !== exp_r.result_1) begin
            $error("result_1 exp %0d got %0d", exp_r.result_1, got.result_1); errors++;
         end
         if (got.result_2 !== exp_r.result_2) begin
            $error("result_2 exp %0d got %0d", exp_r.result_2, got.result_2); errors++;
         end
         if (got.result_3 !== exp_r.result_3) begin
            $error("result_3 exp %0d got %0d", exp_r.result_3, got.result_3); errors++;
         end
         if (got.result_4 !== exp_r.result_4) begin
            $error("result_4 exp %0d got %0d", exp_r.result_4, got.result_4); errors++;
         end
         if (got.result_5 !== exp_r.result_5) begin
            $error("result_5 exp %0d got %0d", exp_r.result_5, got.result_5); errors++;
         end
         if (got.result_6 !== exp_r.result_6) begin
            $error("result_6 exp %0d got %0d", exp_r.result_6, got.result_6); errors++;
         end
         if (got.result_7 !== exp_r.result_7) begin
            $error("result_7 exp %0d got %0d", exp_r.result_7, got.result_7); errors++;
         end
         if (got.saturated !== exp_r.saturated) begin
            $error("saturated exp %0b got %0b", exp_r.saturated, got.saturated); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bnt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bnt_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   bn_scoreboard sb = new();
   int  dog_count  = 0;
   bit  hold_rsp   = 1'b0;   // asks the receiver for one long hold-off
   bit  sink_quiet = 1'b0;   // receiver never stalls while set

   batch_norm_train_forward #(.BATCH(NB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // monitor: checks results and counts idle cycles for the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
             (csr_valid && csr_ready))
            dog_count <= 0;
         else
            dog_count <= dog_count + 1;
         if (dog_count >= DOG_LIMIT) begin
            $display("timeout: no progress");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver: random stall per result, plus one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = sink_quiet ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 3) == 0) gap = 0;   // runs with no stall
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic write_epsilon(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.eps_val = value;
   endtask

   // waits until every expected result is back, then lets the pipe settle
   task automatic drain_results();
      while (sb.norm_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // one request; gap is the number of idle cycles before offering it
   task automatic send_request(input bnt_req_type rq, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(rq);
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value(input int mode);
      unique case (mode)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 1023) - 512);   // small magnitudes
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bnt_req_type random_request();
      bnt_req_type rq;
      int style;
      logic [15:0] base;
      rq = {$urandom, $urandom, $urandom, $urandom, $urandom};
      style = $urandom_range(0, 9);
      base  = 16'($urandom);
      if (style < 3) begin
         // clustered batch: small spread, keeps the result in range
         rq.sample_0 = base + 16'($urandom_range(0, 63));
         rq.sample_1 = base + 16'($urandom_range(0, 63));
         rq.sample_2 = base + 16'($urandom_range(0, 63));
         rq.sample_3 = base + 16'($urandom_range(0, 63));
         rq.sample_4 = base + 16'($urandom_range(0, 63));
         rq.sample_5 = base + 16'($urandom_range(0, 63));
         rq.sample_6 = base + 16'($urandom_range(0, 63));
         rq.sample_7 = base + 16'($urandom_range(0, 63));
         rq.scale = pick_value(3);
         rq.shift = pick_value(3);
      end else if (style == 3) begin
         // constant batch: zero variance
         rq.sample_0 = base; rq.sample_1 = base; rq.sample_2 = base; rq.sample_3 = base;
         rq.sample_4 = base; rq.sample_5 = base; rq.sample_6 = base; rq.sample_7 = base;
      end else if (style == 4) begin
         rq.sample_0 = pick_value($urandom_range(0, 4));
         rq.sample_7 = pick_value($urandom_range(0, 4));
         rq.scale    = pick_value($urandom_range(0, 4));
         rq.shift    = pick_value($urandom_range(0, 4));
      end
      return rq;
   endfunction

   bnt_req_type rq;
   logic [15:0] eps_set[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd0};

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, zero variance, zero denominator
      write_epsilon(16'd0);
      rq = '0;                                      // zero denominator
      send_request(rq, 0);
      rq = {10{16'h1234}}; rq.scale = 16'h7FFF; rq.shift = 16'h8000;
      send_request(rq, 0);
      rq = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
            16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF};
      send_request(rq, 0);
      rq.scale = 16'h8000; rq.shift = 16'h8000;
      send_request(rq, 1);
      rq = '0; rq.sample_3 = 16'h0001; rq.scale = 16'h0100;
      send_request(rq, 0);                          // tiny variance
      rq = {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000};
      send_request(rq, 0);
      rq = {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
            16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF};
      send_request(rq, 2);
      idle_input();
      drain_results();
      write_epsilon(16'hFFFF);
      rq = '1;
      send_request(rq, 0);
      rq = '0; rq.sample_0 = 16'h0100; rq.scale = 16'h0100; rq.shift = 16'h7FFF;
      send_request(rq, 0);
      rq = {16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00, 16'h4000,
            16'hC000, 16'h0001, 16'h8000, 16'h7FFF};
      send_request(rq, 0);
      rq = 160'h5555_AAAA_5555_AAAA_5555_AAAA_5555_AAAA_5555_AAAA;
      send_request(rq, 0);
      idle_input();
      drain_results();

      // random phases over several epsilon settings
      for (int ph = 0; ph < 5; ph++) begin
         write_epsilon(ph == 3 ? 16'($urandom) : eps_set[ph]);
         if (ph == 1) hold_rsp = 1'b1;             // fill the pipe against a stall
         for (int n = 0; n < 110; n++) begin
            send_request(random_request(),
                         (ph == 1 || n % 40 < 10) ? 0 : $urandom_range(0, 15));
            if (n == 60) begin
               // sender waits for every outstanding result
               idle_input();
               while (sb.norm_q.size() != 0) @(posedge clock);
            end
         end
         idle_input();
         drain_results();
      end

      sink_quiet = 1'b1;
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0 && sb.norm_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
